// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvfp assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvfp assertion failed");

`endif

// ===== design/tvfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tvfp_pkg
// shared constants, types and command/status structs of the frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tvfp_pkg;

  localparam int FRAME_BUF_SIZE = 256;
  localparam int TAG_MAX        = 16;
  localparam int VALUE_MAX      = 32;

  localparam int TAG_DEPTH = TAG_MAX - 1;
  localparam int VAL_DEPTH = VALUE_MAX - 1;
  localparam int TL_W      = $clog2(TAG_MAX);
  localparam int VL_W      = $clog2(VALUE_MAX);
  localparam int TI_W      = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
  localparam int VI_W      = (VAL_DEPTH > 1) ? $clog2(VAL_DEPTH) : 1;
  localparam int FC_W      = $clog2(FRAME_BUF_SIZE);

  localparam logic [7:0] CH_STX     = 8'h02;
  localparam logic [7:0] CH_ETX     = 8'h03;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] SUM_MASK   = 8'h3F;
  localparam logic [7:0] SUM_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    KIND_TAG   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FP_TAG   = 2'd0,
    FP_VALUE = 2'd1,
    FP_REST  = 2'd2
  } field_pos_t;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_END,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_end;
    logic load_char;
  } cmd_t;

  typedef struct packed {
    logic ev_end;
    logic group_ok;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/tvfp_dpath.sv =====
// ----------------------------------------------------------------------------
// tvfp_dpath
// frame and group state, tag/value stores, checksum check and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvfp_dpath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        rx_byte,
  input  wire tvfp_pkg::cmd_t    cmd,
  output tvfp_pkg::stat_t        stat,
  input  wire logic              res_stall,
  output logic                   res_valid,
  output logic [1:0]             kind,
  output logic [7:0]             char_byte,
  output logic                   last_of_run,
  output logic                   frame_status
);

  logic                      phase_frame;
  logic [tvfp_pkg::FC_W-1:0] frame_count;
  logic                      in_group;
  logic [7:0]                running_sum;
  logic [7:0]                previous_byte;
  logic                      group_nonzero;
  tvfp_pkg::field_pos_t      field_pos;
  logic [tvfp_pkg::TL_W-1:0] tag_length;
  logic [tvfp_pkg::VL_W-1:0] value_length;
  logic                      field_overflow;
  logic                      end_status;
  logic                      emit_tag;
  logic [tvfp_pkg::TL_W-1:0] tag_rd;
  logic [tvfp_pkg::VL_W-1:0] val_rd;

  logic [7:0] tag_store [tvfp_pkg::TAG_DEPTH];
  logic [7:0] value_store [tvfp_pkg::VAL_DEPTH];

  logic       is_etx, is_tab, is_cr, count_full, add_byte, tag_room, val_room;
  logic [7:0] sum_diff, sum_expect;
  logic       sum_ok;

  assign is_etx     = (rx_byte == tvfp_pkg::CH_ETX);
  assign is_tab     = (rx_byte == tvfp_pkg::CH_TAB);
  assign is_cr      = (rx_byte == tvfp_pkg::CH_CR);
  assign count_full = (frame_count == tvfp_pkg::FC_W'(tvfp_pkg::FRAME_BUF_SIZE - 1));
  assign add_byte   = cmd.accept && phase_frame && !is_etx && !count_full && in_group
                      && !is_cr;
  assign tag_room   = (tag_length < tvfp_pkg::TL_W'(tvfp_pkg::TAG_DEPTH));
  assign val_room   = (value_length < tvfp_pkg::VL_W'(tvfp_pkg::VAL_DEPTH));

  // checksum over all group bytes but the last, against the last
  assign sum_diff   = running_sum - previous_byte;
  assign sum_expect = (sum_diff & tvfp_pkg::SUM_MASK) + tvfp_pkg::SUM_OFFSET;
  assign sum_ok     = (sum_expect == previous_byte);

  always_comb begin
    stat.ev_end    = phase_frame && (is_etx || count_full);
    stat.group_ok  = phase_frame && !is_etx && !count_full && in_group && is_cr
                     && group_nonzero && sum_ok && (field_pos == tvfp_pkg::FP_REST)
                     && !field_overflow && (tag_length != '0) && (value_length != '0);
    stat.out_free  = !res_valid || !res_stall;
    stat.emit_last = !emit_tag && (val_rd == value_length - tvfp_pkg::VL_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_frame    <= 1'b0;
      frame_count    <= '0;
      in_group       <= 1'b0;
      running_sum    <= '0;
      previous_byte  <= '0;
      group_nonzero  <= 1'b0;
      field_pos      <= tvfp_pkg::FP_TAG;
      tag_length     <= '0;
      value_length   <= '0;
      field_overflow <= 1'b0;
      end_status     <= 1'b0;
      emit_tag       <= 1'b0;
      tag_rd         <= '0;
      val_rd         <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (!phase_frame) begin
          if (rx_byte == tvfp_pkg::CH_STX) begin
            phase_frame <= 1'b1;
            frame_count <= '0;
            in_group    <= 1'b0;
          end
        end else if (is_etx || count_full) begin
          phase_frame <= 1'b0;
          frame_count <= '0;
          in_group    <= 1'b0;
          end_status  <= !is_etx;
        end else begin
          frame_count <= frame_count + tvfp_pkg::FC_W'(1);
          if (!in_group) begin
            if (rx_byte == tvfp_pkg::CH_LF) begin
              in_group       <= 1'b1;
              running_sum    <= '0;
              previous_byte  <= '0;
              group_nonzero  <= 1'b0;
              field_pos      <= tvfp_pkg::FP_TAG;
              tag_length     <= '0;
              value_length   <= '0;
              field_overflow <= 1'b0;
            end
          end else if (is_cr) begin
            in_group <= 1'b0;
            emit_tag <= 1'b1;
            tag_rd   <= '0;
            val_rd   <= '0;
          end else begin
            running_sum   <= running_sum + rx_byte;
            previous_byte <= rx_byte;
            group_nonzero <= 1'b1;
            case (field_pos)
              tvfp_pkg::FP_TAG: begin
                if (is_tab) begin
                  field_pos <= tvfp_pkg::FP_VALUE;
                end else if (tag_room) begin
                  tag_length <= tag_length + tvfp_pkg::TL_W'(1);
                end else begin
                  field_overflow <= 1'b1;
                end
              end
              tvfp_pkg::FP_VALUE: begin
                if (is_tab) begin
                  field_pos <= tvfp_pkg::FP_REST;
                end else if (val_room) begin
                  value_length <= value_length + tvfp_pkg::VL_W'(1);
                end else begin
                  field_overflow <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      if (cmd.load_char) begin
        if (emit_tag) begin
          tag_rd <= tag_rd + tvfp_pkg::TL_W'(1);
          if (tag_rd == tag_length - tvfp_pkg::TL_W'(1)) begin
            emit_tag <= 1'b0;
          end
        end else begin
          val_rd <= val_rd + tvfp_pkg::VL_W'(1);
        end
      end

      if (cmd.load_end || cmd.load_char) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // character stores
  always_ff @(posedge clk) begin
    if (add_byte && !is_tab && (field_pos == tvfp_pkg::FP_TAG) && tag_room) begin
      tag_store[tag_length[tvfp_pkg::TI_W-1:0]] <= rx_byte;
    end
    if (add_byte && !is_tab && (field_pos == tvfp_pkg::FP_VALUE) && val_room) begin
      value_store[value_length[tvfp_pkg::VI_W-1:0]] <= rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_end) begin
      kind         <= tvfp_pkg::KIND_END;
      char_byte    <= '0;
      last_of_run  <= 1'b1;
      frame_status <= end_status;
    end else if (cmd.load_char) begin
      frame_status <= 1'b0;
      if (emit_tag) begin
        kind        <= tvfp_pkg::KIND_TAG;
        char_byte   <= tag_store[tag_rd[tvfp_pkg::TI_W-1:0]];
        last_of_run <= 1'b0;
      end else begin
        kind        <= tvfp_pkg::KIND_VALUE;
        char_byte   <= value_store[val_rd[tvfp_pkg::VI_W-1:0]];
        last_of_run <= stat.emit_last;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tvfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tvfp_ctrl
// sequencer: byte intake, frame-end result and character emission
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvfp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            rx_valid,
  output logic                 rx_stall,
  input  wire tvfp_pkg::stat_t stat,
  output tvfp_pkg::cmd_t       cmd
);

  tvfp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvfp_pkg::ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    rx_stall      = 1'b1;
    case (state)
      tvfp_pkg::ST_ACCEPT: begin
        rx_stall   = 1'b0;
        cmd.accept = rx_valid;
        if (rx_valid) begin
          if (stat.ev_end) begin
            state_next = tvfp_pkg::ST_END;
          end else if (stat.group_ok) begin
            state_next = tvfp_pkg::ST_EMIT;
          end
        end
      end
      tvfp_pkg::ST_END: begin
        if (stat.out_free) begin
          cmd.load_end = 1'b1;
          state_next   = tvfp_pkg::ST_ACCEPT;
        end
      end
      tvfp_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_char = 1'b1;
          if (stat.emit_last) begin
            state_next = tvfp_pkg::ST_ACCEPT;
          end
        end
      end
      default: begin
        state_next = tvfp_pkg::ST_ACCEPT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/tag_value_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// tag_value_frame_parser_top
// parses STX/ETX framed LF..CR tag/value groups, emits checked groups
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// rx        in   rx_valid/rx_stall    rx_byte
// res       out  res_valid/res_stall  kind, char_byte, last_of_run, frame_status
//
// a byte that causes no result leaves rx free for the next byte
// a CR closing a valid group emits its tag_length + value_length stored chars
// (max 46), tag then value, one per cycle unless res_stall holds; rx stalled meanwhile
// ETX or frame overflow loads one frame-end beat through the result register
// res_stall holds the result register and pauses emission; rst clears control,
// the character stores are not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tag_value_frame_parser_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [1:0]      kind,
  output logic [7:0]      char_byte,
  output logic            last_of_run,
  output logic            frame_status
);

  tvfp_pkg::cmd_t  cmd;
  tvfp_pkg::stat_t stat;

  tvfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tvfp_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .res_stall    (res_stall),
    .res_valid    (res_valid),
    .kind         (kind),
    .char_byte    (char_byte),
    .last_of_run  (last_of_run),
    .frame_status (frame_status)
  );

endmodule

`default_nettype wire

// ===== design/tvfp_checker.sv =====
// ----------------------------------------------------------------------------
// tvfp_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tvfp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic [1:0] kind,
  input wire logic [7:0] char_byte,
  input wire logic       last_of_run,
  input wire logic       frame_status
);

  `ASSERT_NEXT(a_hold, clk, rst, res_valid && res_stall, res_valid && $stable(kind) && $stable(char_byte) && $stable(last_of_run) && $stable(frame_status))
  `ASSERT_IMPLY(a_end_form, clk, rst, res_valid && (kind == tvfp_pkg::KIND_END), (char_byte == 8'd0) && last_of_run)
  `ASSERT_IMPLY(a_char_status, clk, rst, res_valid && (kind != tvfp_pkg::KIND_END), !frame_status)
  `ASSERT_NEXT(a_run_gapless, clk, rst, res_valid && !res_stall && !last_of_run, res_valid && (kind != tvfp_pkg::KIND_END))

endmodule

bind tag_value_frame_parser_top tvfp_checker u_tvfp_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .kind         (kind),
  .char_byte    (char_byte),
  .last_of_run  (last_of_run),
  .frame_status (frame_status)
);

`default_nettype wire
